/* design/irpwc_pkg.sv */
// irpwc_pkg: shared types and constants for the ir pulse width capture block
// no dependencies; imported by every irpwc module and the top level
`default_nettype none

package irpwc_pkg;

  // edge store limit and the widths that follow from it
  localparam int unsigned MaxEdges  = 4096;
  localparam int unsigned EdgeCntW  = 13;
  localparam int unsigned EdgeIdxW  = 12;
  localparam int unsigned TickW     = 16;
  localparam int unsigned MinEdgesW = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [TickW-1:0]     TimeoutReset  = TickW'(60000);
  localparam logic [MinEdgesW-1:0] MinEdgesReset = MinEdgesW'(10);
  localparam logic [EdgeCntW-1:0]  MaxEdgesCnt   = EdgeCntW'(MaxEdges);
  localparam logic [TickW-1:0]     TickMax       = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_MIN_EDGES = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_RECORD   = 2'd0,
    ST_VALID    = 2'd1,
    ST_SHORT    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_ARMED   = 3'b010,
    PH_CAPTURE = 3'b100
  } phase_e;

  typedef struct packed {
    logic ir_level;
    logic arm;
  } in_word_t;

  typedef struct packed {
    status_e               status;
    logic [TickW-1:0]      duration;
    logic [EdgeIdxW-1:0]   edge_index;
    logic [EdgeCntW-1:0]   edge_total;
  } out_word_t;

  typedef struct packed {
    logic [TickW-1:0]     timeout_ticks;
    logic [MinEdgesW-1:0] min_edges;
  } cfg_t;

endpackage

`default_nettype wire

/* design/ir_pulse_width_capture.sv */
// ir_pulse_width_capture: top level of the infrared remote learning capture block
// depends on irpwc_pkg, irpwc_cfg, irpwc_core, irpwc_out
//
// usage
//   input channel: one word per timer tick (ir_level, arm), taken when
//   in_valid_i is high and in_stall_o low. pulse arm while idle, then the
//   first low level starts a capture. each mark or space then comes out as a
//   duration record (status 0) with its index; a wait past timeout_ticks
//   gives an end record: valid, too short (edge count not above min_edges)
//   or overflow when the edge store limit is reached.
//   output channel: result words on out_valid_o / out_stall_i; ticks that
//   end no mark or space and no capture give no word.
//   config: cfg_valid_i with cfg_index_i (0 timeout, 1 min edges) and
//   cfg_data_i; always ready, write only while idle.
//   timing: one word per cycle while in_stall_o is low; a result appears in the
//   cycle after its tick, set by the single result register after the capture logic.
//   stall: while a result waits under out_stall_i, in_stall_o is raised;
//   the word taken in the same cycle frees the slot for a new tick.
//   reset: asynchronous, returns to idle with timeout 60000 and min edges 10.
`default_nettype none

module ir_pulse_width_capture (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  irpwc_pkg::in_word_t            in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output irpwc_pkg::out_word_t           out_data_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [irpwc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [irpwc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import irpwc_pkg::*;

  cfg_t      cfg;
  logic      accept;
  logic      res_valid;
  out_word_t res;

  // register writes never wait
  assign cfg_ready_o = 1'b1;

  // tick word is taken whenever the result slot is free or draining
  assign accept = in_valid_i & ~in_stall_o;

  irpwc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  irpwc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_word_i   (in_data_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  irpwc_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept & res_valid),
    .res_i        (res),
    .full_stall_o (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

/* design/irpwc_cfg.sv */
// irpwc_cfg: configuration registers for timeout and minimum edge count
// depends on irpwc_pkg
`default_nettype none

module irpwc_cfg (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  input  wire [irpwc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [irpwc_pkg::CfgDataW-1:0]  cfg_data_i,
  output irpwc_pkg::cfg_t                cfg_o
);
  import irpwc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TimeoutReset;
      cfg_q.min_edges     <= MinEdgesReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT:   cfg_q.timeout_ticks <= cfg_data_i[TickW-1:0];
        CFG_MIN_EDGES: cfg_q.min_edges     <= cfg_data_i[MinEdgesW-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/irpwc_core.sv */
// irpwc_core: capture state machine, tick and edge counters, result forming
// depends on irpwc_pkg
`default_nettype none

module irpwc_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   accept_i,
  input  irpwc_pkg::in_word_t   in_word_i,
  input  irpwc_pkg::cfg_t       cfg_i,
  output logic                  res_valid_o,
  output irpwc_pkg::out_word_t  res_o
);
  import irpwc_pkg::*;

  phase_e              phase_q, phase_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic [EdgeCntW-1:0] edges_q, edges_d;

  logic             awaited;
  logic [TickW-1:0] dur;

  // even index waits for high (end of mark), odd for low (end of space)
  assign awaited = ~edges_q[0];
  assign dur     = (tick_q == TickMax) ? TickMax : tick_q + TickW'(1);

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    edges_d     = edges_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.edge_total = edges_q;
    case (phase_q)
      PH_ARMED: begin
        if (!in_word_i.ir_level) begin
          phase_d = PH_CAPTURE;
          tick_d  = '0;
          edges_d = '0;
        end
      end
      PH_CAPTURE: begin
        res_o.edge_total = edges_q;
        if (in_word_i.ir_level == awaited) begin
          res_valid_o = 1'b1;
          if (edges_q >= MaxEdgesCnt) begin
            res_o.status = ST_OVERFLOW;
            phase_d      = PH_IDLE;
          end else begin
            res_o.status     = ST_RECORD;
            res_o.duration   = dur;
            res_o.edge_index = edges_q[EdgeIdxW-1:0];
            res_o.edge_total = '0;
            edges_d          = edges_q + EdgeCntW'(1);
            tick_d           = '0;
          end
        end else if (tick_q >= cfg_i.timeout_ticks) begin
          res_valid_o  = 1'b1;
          res_o.status = (edges_q > EdgeCntW'(cfg_i.min_edges)) ? ST_VALID : ST_SHORT;
          phase_d      = PH_IDLE;
        end else begin
          tick_d = tick_q + TickW'(1);
        end
      end
      default: begin
        // idle; arm tick does not look at the level
        phase_d = in_word_i.arm ? PH_ARMED : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      edges_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      edges_q <= edges_d;
    end
  end

`ifndef SYNTHESIS
  // an end record always sends the block back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o && res_o.status != ST_RECORD |=> phase_q == PH_IDLE)
    else $error("irpwc_core: end record without return to idle");

  // a duration record is never zero and restarts the tick count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o && res_o.status == ST_RECORD
      |-> res_o.duration != '0 ##1 tick_q == '0)
    else $error("irpwc_core: bad duration record");

  // edge counter never passes the store limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    edges_q <= MaxEdgesCnt)
    else $error("irpwc_core: edge count beyond store limit");
`endif

endmodule

`default_nettype wire

/* design/irpwc_out.sv */
// irpwc_out: result register between the capture core and the output channel
// depends on irpwc_pkg
`default_nettype none

module irpwc_out (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   load_i,
  input  irpwc_pkg::out_word_t  res_i,
  output logic                  full_stall_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output irpwc_pkg::out_word_t  out_data_o
);
  import irpwc_pkg::*;

  logic      valid_q, valid_d;
  out_word_t data_q;

  // the slot frees in the same cycle its word is taken
  assign full_stall_o = valid_q & out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire
